// ===== sv/dav_pkg.sv =====
// Shared types and constants for the dominant axis variance selector.
`timescale 1ns / 1ps
`default_nettype none

package dav_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int SAMPLE_BITS  = 16;
	localparam int AXES         = 3;
	localparam int AXIS_W       = 2;

	localparam int LOG_W = $clog2(WINDOW_DEPTH);
	localparam int PTR_W = (LOG_W > 0) ? LOG_W : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int SUM_W = SAMPLE_BITS + LOG_W;
	localparam int SSQ_W = 2 * SAMPLE_BITS + LOG_W;
	localparam int MET_W = 2 * SAMPLE_BITS + 2 * LOG_W - 1;

	typedef logic [AXIS_W-1:0] axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef logic [AXES-1:0] [SAMPLE_BITS-1:0] axes_t;
	typedef logic [MET_W-1:0] metric_t;

	typedef struct packed {
		smp_t x_sample;
		smp_t y_sample;
		smp_t z_sample;
	} in_item_t;

	typedef struct packed {
		smp_t  chosen_value;
		axis_t chosen_index;
		logic  window_full;
	} out_item_t;

	typedef struct packed {
		axes_t old;
		logic  evict;
		logic  full;
	} ring_info_t;

	typedef struct packed {
		logic                     valid;
		logic                     full;
		axes_t                    vals;
		metric_t [AXES-1:0]       metric;
	} stat_t;

endpackage

`default_nettype wire

// ===== sv/dav_ring.sv =====
// Sample ring with write pointer, fill count and prefetched oldest entry.
`timescale 1ns / 1ps
`default_nettype none

module dav_ring import dav_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire axes_t      wr_data,
	output      ring_info_t info
);

	axes_t             mem [WINDOW_DEPTH];
	axes_t             rd_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  wp_inc;
	logic [PTR_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  fill_q;

	assign wp_inc  = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rd_addr = wr_en ? wp_inc : wp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_inc;
			if (fill_q < CNT_W'(WINDOW_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign info.old   = rd_q;
	assign info.evict = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign info.full  = (fill_q >= CNT_W'(WINDOW_DEPTH - 1));

endmodule

`default_nettype wire

// ===== sv/dav_stats.sv =====
// Square, running-sum update and variance metric stages.
`timescale 1ns / 1ps
`default_nettype none

module dav_stats import dav_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       item_valid,
	input  wire axes_t      item_vals,
	input  wire ring_info_t ring,
	output      stat_t      stat
);

	logic valid_s1, valid_s2, valid_s3;
	logic evict_s1, full_s1, full_s2, full_s3;
	axes_t vals_s1, old_s1, vals_s2, old_s2, vals_s3;
	axes_t old_m;

	logic [AXES-1:0] [SQ_W-1:0]  sqn_d, sqo_d, sqn_s2, sqo_s2;
	logic [AXES-1:0] [SUM_W-1:0] sum_q, sum_d;
	logic [AXES-1:0] [SSQ_W-1:0] ssq_q, ssq_d;
	metric_t          [AXES-1:0] metric_d;

	always_comb begin : square_calc
		logic signed [SQ_W-1:0] vw;
		logic signed [SQ_W-1:0] ow;
		for (int j = 0; j < AXES; j++) begin
			old_m[j] = evict_s1 ? old_s1[j] : '0;
			vw       = SQ_W'($signed(vals_s1[j]));
			ow       = SQ_W'($signed(old_m[j]));
			sqn_d[j] = vw * vw;
			sqo_d[j] = ow * ow;
		end
	end

	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			sum_d[j] = sum_q[j] + SUM_W'($signed(vals_s2[j])) - SUM_W'($signed(old_s2[j]));
			ssq_d[j] = ssq_q[j] + SSQ_W'(sqn_s2[j]) - SSQ_W'(sqo_s2[j]);
		end
	end

	always_comb begin : metric_calc
		logic signed [2*SUM_W-1:0] sw;
		logic signed [2*SUM_W-1:0] prod;
		logic        [2*SUM_W-1:0] scaled;
		logic        [2*SUM_W-1:0] diff;
		for (int j = 0; j < AXES; j++) begin
			sw          = (2*SUM_W)'($signed(sum_q[j]));
			prod        = sw * sw;
			scaled      = (2*SUM_W)'(ssq_q[j]) * (2*SUM_W)'(WINDOW_DEPTH);
			diff        = scaled - prod;
			metric_d[j] = diff[MET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			sum_q    <= '0;
			ssq_q    <= '0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				sum_q <= sum_d;
				ssq_q <= ssq_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vals_s1  <= item_vals;
			old_s1   <= ring.old;
			evict_s1 <= ring.evict;
			full_s1  <= ring.full;
			vals_s2  <= vals_s1;
			old_s2   <= old_m;
			sqn_s2   <= sqn_d;
			sqo_s2   <= sqo_d;
			full_s2  <= full_s1;
			vals_s3  <= vals_s2;
			full_s3  <= full_s2;
		end
	end

	assign stat.valid  = valid_s3;
	assign stat.full   = full_s3;
	assign stat.vals   = vals_s3;
	assign stat.metric = metric_d;

endmodule

`default_nettype wire

// ===== sv/dav_select.sv =====
// Axis selection stage and result register.
`timescale 1ns / 1ps
`default_nettype none

module dav_select import dav_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire stat_t     stat,
	output      logic      result_valid,
	output      out_item_t result
);

	logic               valid_s4, full_s4;
	axes_t              vals_s4;
	metric_t [AXES-1:0] metric_s4;
	metric_t            best;
	axis_t              best_idx, chosen_q, chosen_d;
	smp_t               chosen_val;
	logic               out_valid_q;
	out_item_t          out_q;

	always_comb begin
		best     = metric_s4[AXIS_X];
		best_idx = AXIS_X;
		if (metric_s4[AXIS_Y] > best) begin
			best     = metric_s4[AXIS_Y];
			best_idx = AXIS_Y;
		end
		if (metric_s4[AXIS_Z] > best) begin
			best     = metric_s4[AXIS_Z];
			best_idx = AXIS_Z;
		end
	end

	assign chosen_d = full_s4 ? best_idx : chosen_q;

	always_comb begin
		case (chosen_d)
			AXIS_X: begin
				chosen_val = $signed(vals_s4[AXIS_X]);
			end
			AXIS_Z: begin
				chosen_val = $signed(vals_s4[AXIS_Z]);
			end
			default: begin
				chosen_val = $signed(vals_s4[AXIS_Y]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			chosen_q    <= AXIS_Y;
		end else if (advance) begin
			valid_s4    <= stat.valid;
			out_valid_q <= valid_s4;
			if (valid_s4) begin
				chosen_q <= chosen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			full_s4   <= stat.full;
			vals_s4   <= stat.vals;
			metric_s4 <= stat.metric;
			if (valid_s4) begin
				out_q.chosen_value <= chosen_val;
				out_q.chosen_index <= chosen_d;
				out_q.window_full  <= full_s4;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_index_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s4 |=> result.chosen_index == chosen_q)
		else $error("result index differs from held axis");

	a_hold_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s4 && !full_s4 |=> chosen_q == $past(chosen_q))
		else $error("axis changed before window was full");

	a_full_flag_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s4 |=> result_valid && result.window_full == $past(full_s4))
		else $error("result window flag mismatch");
`endif

endmodule

`default_nettype wire

// ===== sv/dominant_axis_variance_selector_unit.sv =====
// Top level of the dominant axis variance selector.
//
// Usage:
//   sample channel: one three-axis sample per item (sample_valid/sample_ready).
//   result channel: one item per sample with the sample on the selected
//   axis, the axis index and a flag set once the window is full.
//   Throughput: one item per cycle unless the pipeline is stalled; the
//   limit is the running-sum update, a single read-modify-write of the
//   per-axis sums each cycle. The result passes through square, sum
//   update, metric, select and the result register.
//   The ring memory prefetches the oldest entry into a read register, so an
//   item may be accepted on every cycle.
//   Reset: sums, write pointer and fill count clear, the selected axis
//   starts at y, and the pipeline empties. The ring holds no valid data
//   until written and needs no clearing pass.
//   Stall: while the result waits to be taken, the whole pipeline holds
//   and sample_ready drops; it is high whenever the result register is
//   empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

module dominant_axis_variance_selector_unit import dav_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sample_valid,
	output      logic      sample_ready,
	input  wire in_item_t  sample,
	output      logic      result_valid,
	input  wire logic      result_ready,
	output      out_item_t result
);

	logic       advance;
	logic       accept;
	axes_t      vals;
	ring_info_t ring;
	stat_t      stat;

	assign advance      = !result_valid || result_ready;
	assign sample_ready = advance;
	assign accept       = sample_valid && advance;

	assign vals[AXIS_X] = sample.x_sample;
	assign vals[AXIS_Y] = sample.y_sample;
	assign vals[AXIS_Z] = sample.z_sample;

	dav_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (vals),
		.info    (ring)
	);

	dav_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_valid (sample_valid),
		.item_vals  (vals),
		.ring       (ring),
		.stat       (stat)
	);

	dav_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
